>>> design/hci_h4_pkg.sv
// hci h4 deframer package: register map, reset values, packet types and shared structs
package hci_h4_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int HLEN_W      = 3;
    localparam int MASK_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int KIND_W      = 2;
    localparam int TYPE_W      = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACL_HLEN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCO_HLEN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_HLEN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ISO_HLEN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_HLEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK       = 3'd5;

    // reset values
    localparam logic [HLEN_W-1:0] RST_ACL_HLEN   = 3'd4;
    localparam logic [HLEN_W-1:0] RST_SCO_HLEN   = 3'd3;
    localparam logic [HLEN_W-1:0] RST_EVENT_HLEN = 3'd2;
    localparam logic [HLEN_W-1:0] RST_ISO_HLEN   = 3'd4;
    localparam logic [HLEN_W-1:0] RST_CMD_HLEN   = 3'd3;
    localparam logic [MASK_W-1:0] RST_MASK       = 4'hF;

    // h4 packet indicators
    localparam logic [TYPE_W-1:0] TYPE_CMD = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_ACL = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_SCO = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_EVT = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_ISO = 3'd5;

    typedef struct packed {
        logic [HLEN_W-1:0] acl_hlen;
        logic [HLEN_W-1:0] sco_hlen;
        logic [HLEN_W-1:0] event_hlen;
        logic [HLEN_W-1:0] iso_hlen;
        logic [HLEN_W-1:0] cmd_hlen;
        logic [MASK_W-1:0] deliver_mask;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [KIND_W-1:0] packet_kind;
        logic              in_header;
        logic              is_last;
        logic              bad_type;
    } result_t;

endpackage

>>> design/hci_h4_cfg.sv
// hci h4 deframer configuration register file
module hci_h4_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [hci_h4_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [hci_h4_pkg::CFG_DATA_W-1:0]  wr_data,
    output hci_h4_pkg::cfg_t                   cfg
);

    hci_h4_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.acl_hlen     <= hci_h4_pkg::RST_ACL_HLEN;
            cfg_reg.sco_hlen     <= hci_h4_pkg::RST_SCO_HLEN;
            cfg_reg.event_hlen   <= hci_h4_pkg::RST_EVENT_HLEN;
            cfg_reg.iso_hlen     <= hci_h4_pkg::RST_ISO_HLEN;
            cfg_reg.cmd_hlen     <= hci_h4_pkg::RST_CMD_HLEN;
            cfg_reg.deliver_mask <= hci_h4_pkg::RST_MASK;
        end
        else if (wr_en)
        begin
            case (wr_index)
                hci_h4_pkg::REG_ACL_HLEN:
                    cfg_reg.acl_hlen <= wr_data[hci_h4_pkg::HLEN_W-1:0];
                hci_h4_pkg::REG_SCO_HLEN:
                    cfg_reg.sco_hlen <= wr_data[hci_h4_pkg::HLEN_W-1:0];
                hci_h4_pkg::REG_EVENT_HLEN:
                    cfg_reg.event_hlen <= wr_data[hci_h4_pkg::HLEN_W-1:0];
                hci_h4_pkg::REG_ISO_HLEN:
                    cfg_reg.iso_hlen <= wr_data[hci_h4_pkg::HLEN_W-1:0];
                hci_h4_pkg::REG_CMD_HLEN:
                    cfg_reg.cmd_hlen <= wr_data[hci_h4_pkg::HLEN_W-1:0];
                hci_h4_pkg::REG_MASK:
                    cfg_reg.deliver_mask <= wr_data[hci_h4_pkg::MASK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/hci_h4_framer.sv
// hci h4 deframer packet state machine and per-byte result logic
module hci_h4_framer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hci_h4_pkg::cfg_t              cfg,
    input  logic                          step,
    input  logic [hci_h4_pkg::BYTE_W-1:0] rx_byte,
    output logic                          has_result,
    output hci_h4_pkg::result_t           result
);

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [hci_h4_pkg::TYPE_W-1:0]   kind_reg, kind_next;
    logic [hci_h4_pkg::HLEN_W-1:0]   count_reg, count_next;
    logic [hci_h4_pkg::LEN_W-1:0]    accum_reg, accum_next;
    logic [hci_h4_pkg::LEN_W-1:0]    remain_reg, remain_next;

    logic [hci_h4_pkg::HLEN_W-1:0]   hlen_raw;
    logic [hci_h4_pkg::HLEN_W:0]     hlen;
    logic [hci_h4_pkg::HLEN_W:0]     idx_plus1;
    logic [hci_h4_pkg::HLEN_W:0]     idx_plus2;
    logic                            two_byte_len;
    logic                            known_type;
    logic                            deliver;
    logic [hci_h4_pkg::TYPE_W-1:0]   kind_off;
    logic [hci_h4_pkg::LEN_W-1:0]    len_final;
    logic [hci_h4_pkg::LEN_W-1:0]    remain_dec;
    logic                            last;
    logic                            hdr;

    always_comb
    begin
        case (kind_reg)
            hci_h4_pkg::TYPE_ACL: hlen_raw = cfg.acl_hlen;
            hci_h4_pkg::TYPE_SCO: hlen_raw = cfg.sco_hlen;
            hci_h4_pkg::TYPE_EVT: hlen_raw = cfg.event_hlen;
            hci_h4_pkg::TYPE_ISO: hlen_raw = cfg.iso_hlen;
            default:              hlen_raw = cfg.cmd_hlen;
        endcase
    end

    // a zero length register counts as a one-byte header
    assign hlen = (hlen_raw == '0) ? 4'd1 : {1'b0, hlen_raw};
    assign idx_plus1 = {1'b0, count_reg} + 4'd1;
    assign idx_plus2 = {1'b0, count_reg} + 4'd2;
    assign two_byte_len = (kind_reg == hci_h4_pkg::TYPE_ACL) ||
                          (kind_reg == hci_h4_pkg::TYPE_ISO);
    assign known_type = (rx_byte >= {5'd0, hci_h4_pkg::TYPE_CMD}) &&
                        (rx_byte <= {5'd0, hci_h4_pkg::TYPE_ISO});
    assign kind_off = kind_reg - hci_h4_pkg::TYPE_ACL;
    assign deliver = (kind_reg >= hci_h4_pkg::TYPE_ACL) &&
                     (kind_reg <= hci_h4_pkg::TYPE_ISO) &&
                     cfg.deliver_mask[kind_off[1:0]];
    assign len_final = (two_byte_len && hlen >= 4'd2) ? {rx_byte, accum_reg[7:0]}
                                                      : {8'd0, rx_byte};
    assign remain_dec = remain_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        count_next  = count_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        has_result  = 1'b0;
        last        = 1'b0;
        hdr         = 1'b0;
        result.data_byte   = rx_byte;
        result.packet_kind = '0;
        result.in_header   = 1'b0;
        result.is_last     = 1'b0;
        result.bad_type    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (known_type)
                begin
                    kind_next   = rx_byte[hci_h4_pkg::TYPE_W-1:0];
                    count_next  = '0;
                    accum_next  = '0;
                    remain_next = '0;
                    phase_next  = PH_HEADER;
                end
                else
                begin
                    has_result      = 1'b1;
                    result.bad_type = 1'b1;
                end
            end
            PH_HEADER:
            begin
                hdr = 1'b1;
                if (idx_plus1 >= hlen)
                begin
                    accum_next  = len_final;
                    remain_next = len_final;
                    count_next  = '0;
                    if (len_final == '0)
                    begin
                        last       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    if (two_byte_len && idx_plus2 == hlen)
                    begin
                        accum_next = {8'd0, rx_byte};
                    end
                    count_next = idx_plus1[hci_h4_pkg::HLEN_W-1:0];
                end
                has_result         = deliver;
                result.packet_kind = kind_off[hci_h4_pkg::KIND_W-1:0];
                result.in_header   = hdr;
                result.is_last     = last;
            end
            PH_PAYLOAD:
            begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    last       = 1'b1;
                    phase_next = PH_IDLE;
                end
                has_result         = deliver;
                result.packet_kind = kind_off[hci_h4_pkg::KIND_W-1:0];
                result.in_header   = hdr;
                result.is_last     = last;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            kind_reg   <= '0;
            count_reg  <= '0;
            accum_reg  <= '0;
            remain_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            count_reg  <= count_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
        end
    end

endmodule

>>> design/hci_h4_packet_deframer.sv
// hci h4 packet deframer top level: input register, framer and result register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | rx_byte
//  out     | output    | out_valid / out_stall| data_byte packet_kind in_header is_last
//          |           |                      | bad_type
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index cfg_data
//
//  one byte per cycle sustained while out_stall does not hold back a result; each byte is held in
//  the input register and its result, if any, is written from there into the output register
//  the framer state advances when the input register hands its byte on
//  a held result stalls the input register only if the next byte also has a result
//  reset clears all valid flags and framer state and loads the register defaults
module hci_h4_packet_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [hci_h4_pkg::BYTE_W-1:0]      rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hci_h4_pkg::BYTE_W-1:0]      data_byte,
    output logic [hci_h4_pkg::KIND_W-1:0]      packet_kind,
    output logic                               in_header,
    output logic                               is_last,
    output logic                               bad_type,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hci_h4_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hci_h4_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hci_h4_pkg::cfg_t                cfg;
    hci_h4_pkg::result_t             result;
    hci_h4_pkg::result_t             out_reg;
    logic                            has_result;
    logic                            in_valid_reg;
    logic [hci_h4_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                            out_valid_reg;
    logic                            advance;
    logic                            in_take;

    assign cfg_ready = 1'b1;

    hci_h4_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hci_h4_framer u_framer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    // byte moves on if it yields nothing or the result register frees up
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && has_result)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = out_reg.data_byte;
    assign packet_kind = out_reg.packet_kind;
    assign in_header   = out_reg.in_header;
    assign is_last     = out_reg.is_last;
    assign bad_type    = out_reg.bad_type;

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the hci h4 packet deframer
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hci_h4_pkg::*;

    localparam int PIPE_DEPTH       = 2;
    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 194;
    localparam int SETTLE_LIMIT     = 4000;
    localparam int HOLD_AFTER       = 80;
    localparam int HOLD_CYCLES      = 300;
    localparam int LIMIT_NS         = 1_000_000;

    localparam logic [KIND_W-1:0] KIND_ACL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ISO = 2'd3;

    typedef enum logic [1:0] {FR_IDLE, FR_HEADER, FR_PAYLOAD} frame_phase_t;
    typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_RESULT} row_check_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        row_check_t        chk;
        result_t           r;
    } stim_row_t;

    // reset register values throughout
    localparam stim_row_t DIRECTED [26] = '{
        '{8'h00, ROW_RESULT, '{8'h00, KIND_ACL, 1'b0, 1'b0, 1'b1}},
        '{8'hFF, ROW_RESULT, '{8'hFF, KIND_ACL, 1'b0, 1'b0, 1'b1}},
        '{8'h06, ROW_RESULT, '{8'h06, KIND_ACL, 1'b0, 1'b0, 1'b1}},
        // event with zero length ends on its header
        '{8'(TYPE_EVT), ROW_NONE, '0},
        '{8'hFF, ROW_RESULT, '{8'hFF, KIND_EVT, 1'b1, 1'b0, 1'b0}},
        '{8'h00, ROW_RESULT, '{8'h00, KIND_EVT, 1'b1, 1'b1, 1'b0}},
        // command packets are swallowed
        '{8'(TYPE_CMD), ROW_NONE, '0},
        '{8'h03, ROW_NONE, '0},
        '{8'h0C, ROW_NONE, '0},
        '{8'h00, ROW_NONE, '0},
        '{8'(TYPE_ACL), ROW_NONE, '0},
        '{8'h01, ROW_MODEL, '0},
        '{8'h20, ROW_MODEL, '0},
        '{8'h01, ROW_MODEL, '0},
        '{8'h00, ROW_MODEL, '0},
        '{8'h7F, ROW_MODEL, '0},
        '{8'(TYPE_SCO), ROW_NONE, '0},
        '{8'h05, ROW_MODEL, '0},
        '{8'h00, ROW_MODEL, '0},
        '{8'h01, ROW_MODEL, '0},
        '{8'h80, ROW_MODEL, '0},
        '{8'(TYPE_ISO), ROW_NONE, '0},
        '{8'h00, ROW_MODEL, '0},
        '{8'h00, ROW_MODEL, '0},
        '{8'h00, ROW_MODEL, '0},
        '{8'h00, ROW_RESULT, '{8'h00, KIND_ISO, 1'b1, 1'b1, 1'b0}}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BYTE_W-1:0]      data_byte;
    logic [KIND_W-1:0]      packet_kind;
    logic                   in_header;
    logic                   is_last;
    logic                   bad_type;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    hci_h4_packet_deframer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .packet_kind (packet_kind),
        .in_header   (in_header),
        .is_last     (is_last),
        .bad_type    (bad_type),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // shadow of the register file and of the framer
    cfg_t shadow_cfg = '{RST_ACL_HLEN, RST_SCO_HLEN, RST_EVENT_HLEN, RST_ISO_HLEN,
                         RST_CMD_HLEN, RST_MASK};
    frame_phase_t      fr_phase  = FR_IDLE;
    logic [TYPE_W-1:0] fr_type   = '0;
    logic [2:0]        fr_hcount = '0;
    logic [LEN_W-1:0]  fr_len    = '0;
    logic [LEN_W-1:0]  fr_left   = '0;

    result_t           awaited_bytes [$];
    logic [BYTE_W-1:0] pkt_q [$];
    int                mismatches    = 0;
    int                bytes_in      = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_left     = 0;
    bit                hold_done     = 1'b0;

    function automatic int unsigned hdr_bytes(input logic [TYPE_W-1:0] t);
        logic [HLEN_W-1:0] v;
        case (t)
            TYPE_ACL: v = shadow_cfg.acl_hlen;
            TYPE_SCO: v = shadow_cfg.sco_hlen;
            TYPE_EVT: v = shadow_cfg.event_hlen;
            TYPE_ISO: v = shadow_cfg.iso_hlen;
            default:  v = shadow_cfg.cmd_hlen;
        endcase
        return (v == 0) ? 1 : v;
    endfunction

    // advances the shadow framer by one byte; returns 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
        int unsigned       hlen;
        int unsigned       idx;
        bit                two;
        bit                last;
        bit                hdr;
        logic [TYPE_W-1:0] kind;
        r    = '0;
        last = 1'b0;
        hdr  = 1'b0;
        if (fr_phase == FR_IDLE)
        begin
            if (b >= 8'(TYPE_CMD) && b <= 8'(TYPE_ISO))
            begin
                fr_type   = b[TYPE_W-1:0];
                fr_hcount = '0;
                fr_len    = '0;
                fr_left   = '0;
                fr_phase  = FR_HEADER;
                return 1'b0;
            end
            r.data_byte = b;
            r.bad_type  = 1'b1;
            return 1'b1;
        end
        if (fr_phase == FR_HEADER)
        begin
            hdr  = 1'b1;
            hlen = hdr_bytes(fr_type);
            two  = (fr_type == TYPE_ACL || fr_type == TYPE_ISO);
            idx  = fr_hcount;
            // lengths are read live, so the count may already be past the end
            if (idx + 1 >= hlen)
            begin
                if (two && hlen >= 2)
                    fr_len = {b, fr_len[7:0]};
                else
                    fr_len = {8'h00, b};
                fr_left   = fr_len;
                fr_hcount = '0;
                if (fr_left == 0)
                begin
                    last     = 1'b1;
                    fr_phase = FR_IDLE;
                end
                else
                    fr_phase = FR_PAYLOAD;
            end
            else
            begin
                if (two && idx + 2 == hlen)
                    fr_len = {8'h00, b};
                fr_hcount = 3'(idx + 1);
            end
        end
        else
        begin
            fr_left = fr_left - 16'd1;
            if (fr_left == 0)
            begin
                last     = 1'b1;
                fr_phase = FR_IDLE;
            end
        end
        if (fr_type < TYPE_ACL || fr_type > TYPE_ISO)
            return 1'b0;
        kind = fr_type - TYPE_ACL;
        if (!shadow_cfg.deliver_mask[kind[1:0]])
            return 1'b0;
        r.data_byte   = b;
        r.packet_kind = kind[KIND_W-1:0];
        r.in_header   = hdr;
        r.is_last     = last;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_sink
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got data_byte %0h bad_type %0b",
                         $time, data_byte, bad_type);
                mismatches++;
            end
            else
            begin
                want = awaited_bytes.pop_front();
                check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
                check_field("packet_kind", 16'(want.packet_kind), 16'(packet_kind));
                check_field("in_header", 16'(want.in_header), 16'(in_header));
                check_field("is_last", 16'(want.is_last), 16'(is_last));
                check_field("bad_type", 16'(want.bad_type), 16'(bad_type));
            end
        end
        // one long hold-off early on so the block backs up into its input
        if (!hold_done && bytes_in >= HOLD_AFTER)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic offer_rx_byte(input logic [BYTE_W-1:0] b, input row_check_t chk,
                                 input result_t typed);
        result_t r;
        bit      has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_in++;
        has = deframe_byte(b, r);
        case (chk)
            ROW_MODEL:  if (has) awaited_bytes.push_back(r);
            ROW_RESULT: awaited_bytes.push_back(typed);
            default:    ;
        endcase
    endtask

    // drains the pipe; command and masked bytes may still be in flight after the last result
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (awaited_bytes.size() > 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_bytes.size() > 0)
        begin
            $display("%0t: %0d expected results never arrived, expected %0d, got 0",
                     $time, awaited_bytes.size(), awaited_bytes.size());
            mismatches++;
            awaited_bytes.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic configure(input int p);
        logic [CFG_DATA_W-1:0]  vals [6];
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        case (p)
            1:
            begin
                foreach (vals[i]) vals[i] = 4'd1;
                vals[REG_MASK] = 4'hF;
            end
            2:
            begin
                foreach (vals[i]) vals[i] = 4'd7;
                vals[REG_MASK] = 4'hF;
            end
            3:
            begin
                // zero lengths, one of them via the unused top bit, and no packet kind delivered
                vals[REG_ACL_HLEN]   = 4'd0;
                vals[REG_SCO_HLEN]   = 4'd8;
                vals[REG_EVENT_HLEN] = 4'd0;
                vals[REG_ISO_HLEN]   = 4'd15;
                vals[REG_CMD_HLEN]   = 4'd0;
                vals[REG_MASK]       = 4'h0;
            end
            5:
            begin
                vals[REG_ACL_HLEN]   = 4'd2;
                vals[REG_SCO_HLEN]   = 4'd1;
                vals[REG_EVENT_HLEN] = 4'd7;
                vals[REG_ISO_HLEN]   = 4'd2;
                vals[REG_CMD_HLEN]   = 4'd7;
                vals[REG_MASK]       = 4'b0101;
            end
            default:
                foreach (vals[i]) vals[i] = 4'($urandom_range(15));
        endcase
        // the last write goes to an unused index
        for (int i = 0; i <= 6; i++)
        begin
            idx  = (i < 6) ? 3'(i) : 3'($urandom_range(7, REG_MASK + 1));
            data = (i < 6) ? vals[i] : 4'($urandom_range(15));
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                REG_ACL_HLEN:   shadow_cfg.acl_hlen     = data[HLEN_W-1:0];
                REG_SCO_HLEN:   shadow_cfg.sco_hlen     = data[HLEN_W-1:0];
                REG_EVENT_HLEN: shadow_cfg.event_hlen   = data[HLEN_W-1:0];
                REG_ISO_HLEN:   shadow_cfg.iso_hlen     = data[HLEN_W-1:0];
                REG_CMD_HLEN:   shadow_cfg.cmd_hlen     = data[HLEN_W-1:0];
                REG_MASK:       shadow_cfg.deliver_mask = data;
                default:        ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed packets with random content, some noise and cut-short packets
    function automatic void compose_packet();
        int unsigned       roll;
        int unsigned       pick;
        int unsigned       hlen;
        int unsigned       keep;
        logic [LEN_W-1:0]  plen;
        logic [TYPE_W-1:0] ptype;
        logic [BYTE_W-1:0] hb;
        bit                two;
        pkt_q.delete();
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            repeat ($urandom_range(4, 1)) pkt_q.push_back(8'($urandom));
        end
        else if (roll < 12)
        begin
            if ($urandom_range(7) == 0)
                pkt_q.push_back(8'h00);
            else
                pkt_q.push_back(8'($urandom_range(255, 6)));
        end
        else
        begin
            ptype = 3'($urandom_range(TYPE_ISO, TYPE_CMD));
            hlen  = hdr_bytes(ptype);
            two   = (ptype == TYPE_ACL || ptype == TYPE_ISO);
            pick  = $urandom_range(99);
            if (pick < 70)
                plen = 16'($urandom_range(4));
            else if (pick < 95)
                plen = 16'($urandom_range(40, 5));
            else
                plen = 16'($urandom_range(300, 41));
            if (!two || hlen == 1)
                plen[15:8] = 8'h00;
            pkt_q.push_back(8'(ptype));
            for (int i = 0; i < hlen; i++)
            begin
                hb = 8'($urandom);
                if (i == hlen - 1)
                    hb = (two && hlen >= 2) ? plen[15:8] : plen[7:0];
                else if (two && i == hlen - 2)
                    hb = plen[7:0];
                pkt_q.push_back(hb);
            end
            for (int i = 0; i < plen; i++)
                pkt_q.push_back(8'($urandom));
            if (roll < 18)
            begin
                keep = $urandom_range(pkt_q.size() - 1, 1);
                while (pkt_q.size() > keep)
                    void'(pkt_q.pop_back());
            end
        end
    endfunction

    initial
    begin : stimulus
        int sent;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 38;
        recv_idle_pct = 49;
        foreach (DIRECTED[i])
            offer_rx_byte(DIRECTED[i].b, DIRECTED[i].chk, DIRECTED[i].r);
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p / 3)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p > 0)
                configure(p);
            sent = 0;
            // phases may end mid-packet, so the next writes land inside a transaction
            while (sent < RANDOM_PER_PHASE)
            begin
                compose_packet();
                while (pkt_q.size() > 0 && sent < RANDOM_PER_PHASE)
                begin
                    offer_rx_byte(pkt_q.pop_front(), ROW_MODEL, '0);
                    sent++;
                end
            end
        end
        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/hci_h4_pkg.sv
design/hci_h4_cfg.sv
design/hci_h4_framer.sv
design/hci_h4_packet_deframer.sv
tb/sv/testbench.sv
